// File: rtl/core/mbps_pkg.sv
`timescale 1ns / 1ps
// mbps_pkg: shared constants, types and helpers of the masked byte pattern scanner
// used by mbps_cell, masked_byte_pattern_scanner_unit and its checker; no dependencies

package mbps_pkg;

    // window geometry
    localparam int MAX_PATTERN = 16;
    localparam int POS_W       = $clog2(MAX_PATTERN);
    localparam int LEN_W       = POS_W + 1;

    // configuration register indexes
    localparam logic [2:0] REG_PATTERN_LOW  = 3'd0;
    localparam logic [2:0] REG_PATTERN_HIGH = 3'd1;
    localparam logic [2:0] REG_CARE_MASK    = 3'd2;
    localparam logic [2:0] REG_PATTERN_LEN  = 3'd3;
    localparam logic [2:0] REG_START_ADDR   = 3'd4;

    // kind of a transaction waiting in the compare stage
    localparam logic PEND_MATCH = 1'b0;
    localparam logic PEND_DONE  = 1'b1;

    localparam logic [31:0] LAST_ADDRESS = 32'hFFFF_FFFF;

    // pattern settings every cell compares against
    typedef struct packed {
        logic [MAX_PATTERN-1:0][7:0] pattern;
        logic [MAX_PATTERN-1:0]      care;
        logic [LEN_W-1:0]            length;
    } match_cfg_t;

    // effective pattern length: zero counts as one, saturated at the window depth
    function automatic logic [LEN_W-1:0] eff_length(input logic [4:0] raw);
        logic [LEN_W-1:0] n;
        begin
            if (raw == 5'd0)
                n = LEN_W'(1);
            else if (raw > 5'(MAX_PATTERN))
                n = LEN_W'(MAX_PATTERN);
            else
                n = LEN_W'(raw);
            return n;
        end
    endfunction

endpackage

// File: rtl/core/mbps_cell.sv
`timescale 1ns / 1ps
// mbps_cell: one byte of the scan window with its masked comparator
// depends on mbps_pkg

module mbps_cell
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            shift,      // byte transaction accepted while the scan runs
    input  logic [7:0]                      byte_in,    // from the newer neighbour
    input  logic [mbps_pkg::POS_W-1:0]      position,   // place in the window, 0 newest
    input  mbps_pkg::match_cfg_t            match_cfg,
    output logic [7:0]                      byte_out,   // to the older neighbour
    output logic                            miss
);

    logic [7:0]                      byte_reg;
    logic [7:0]                      byte_next;
    logic [mbps_pkg::LEN_W-1:0]      offset;
    logic [mbps_pkg::POS_W-1:0]      pat_idx;
    logic                            in_use;

    // window byte, moves one place older on every shift
    always_comb
    begin
        byte_next = shift ? byte_in : byte_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            byte_reg <= 8'd0;
        else
            byte_reg <= byte_next;
    end

    // pattern position this cell faces: length - 1 - position
    always_comb
    begin
        offset  = match_cfg.length - mbps_pkg::LEN_W'(1) - {1'b0, position};
        pat_idx = offset[mbps_pkg::POS_W-1:0];
        in_use  = {1'b0, position} < match_cfg.length;
        miss    = in_use && match_cfg.care[pat_idx]
                  && (byte_reg != match_cfg.pattern[pat_idx]);
    end

    assign byte_out = byte_reg;

endmodule

// File: rtl/core/masked_byte_pattern_scanner_unit.sv
`timescale 1ns / 1ps
// masked_byte_pattern_scanner_unit: top level of the wildcard byte pattern scanner
// depends on mbps_pkg and mbps_cell

// The scanner takes one memory byte per clock and reports the start address of every
// window that matches the configured pattern, with wildcard positions cleared in the
// care mask. A row of sixteen window cells shifts on each byte the scan takes in; the cells
// compare in parallel in the cycle after, so a result goes through the compare stage
// and the output register, and a new byte is taken every cycle while the output is free
// or being taken. A read failure, or a byte arriving at address 0xFFFFFFFF, gives one
// result with scan_done set; afterwards bytes are taken and dropped until
// start_address is written, which also restarts the scan. Write configuration only
// while no result is outstanding.

module masked_byte_pattern_scanner_unit
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    // byte stream in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_axis_tuser,   // [0] read_failed
    // results out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] match_address
    output logic [0:0]  m_axis_tuser    // [0] scan_done
);

    localparam int N = mbps_pkg::MAX_PATTERN;

    // configuration registers
    logic [63:0] pat_low_reg;
    logic [63:0] pat_high_reg;
    logic [15:0] care_reg;
    logic [4:0]  len_reg;
    logic        restart;

    // scan state
    logic [31:0]                 addr_reg, addr_next;
    logic [mbps_pkg::LEN_W-1:0]  seen_reg, seen_next;
    logic                        finished_reg, finished_next;

    // compare stage
    logic                        pend_valid_reg, pend_valid_next;
    logic                        pend_kind_reg, pend_kind_next;
    logic [31:0]                 pend_addr_reg, pend_addr_next;

    // output register
    logic                        out_valid_reg, out_valid_next;
    logic [31:0]                 out_addr_reg, out_addr_next;
    logic                        out_done_reg, out_done_next;

    logic                        advance;
    logic                        accept;
    logic                        stop;
    logic                        hit;
    mbps_pkg::match_cfg_t        match_cfg;
    logic [N:0][7:0]             chain;
    logic [N-1:0]                miss;
    logic [mbps_pkg::LEN_W-1:0]  len_eff;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_low_reg  <= 64'd0;
            pat_high_reg <= 64'd0;
            care_reg     <= 16'hFFFF;
            len_reg      <= 5'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mbps_pkg::REG_PATTERN_LOW:  pat_low_reg  <= cfg_data;
                mbps_pkg::REG_PATTERN_HIGH: pat_high_reg <= cfg_data;
                mbps_pkg::REG_CARE_MASK:    care_reg     <= cfg_data[15:0];
                mbps_pkg::REG_PATTERN_LEN:  len_reg      <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    assign restart = cfg_we && (cfg_index == mbps_pkg::REG_START_ADDR);
    assign len_eff = mbps_pkg::eff_length(len_reg);

    always_comb
    begin
        match_cfg.pattern = {pat_high_reg, pat_low_reg};
        match_cfg.care    = care_reg;
        match_cfg.length  = len_eff;
    end

    // handshake: compare stage moves on when the output register is free or taken
    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !pend_valid_reg || advance;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign stop          = s_axis_tuser[0] || (addr_reg == mbps_pkg::LAST_ADDRESS);

    // row of window cells, newest byte at cell 0
    assign chain[0] = s_axis_tdata;

    genvar k;
    generate
        for (k = 0; k < N; k++)
        begin : g_cell
            mbps_cell u_cell
            (
                .clk       (clk),
                .rst_n     (rst_n),
                .shift     (accept && !finished_reg && !stop),
                .byte_in   (chain[k]),
                .position  (mbps_pkg::POS_W'(k)),
                .match_cfg (match_cfg),
                .byte_out  (chain[k+1]),
                .miss      (miss[k])
            );
        end
    endgenerate

    assign hit = ~|miss;

    // scan state and compare stage
    always_comb
    begin
        addr_next       = addr_reg;
        seen_next       = seen_reg;
        finished_next   = finished_reg;
        pend_valid_next = pend_valid_reg;
        pend_kind_next  = pend_kind_reg;
        pend_addr_next  = pend_addr_reg;

        if (advance)
            pend_valid_next = 1'b0;

        if (accept && !finished_reg)
        begin
            if (stop)
            begin
                finished_next   = 1'b1;
                pend_valid_next = 1'b1;
                pend_kind_next  = mbps_pkg::PEND_DONE;
            end
            else
            begin
                if (seen_reg != mbps_pkg::LEN_W'(N))
                    seen_next = seen_reg + mbps_pkg::LEN_W'(1);
                addr_next       = addr_reg + 32'd1;
                pend_valid_next = seen_next >= len_eff;
                pend_kind_next  = mbps_pkg::PEND_MATCH;
                pend_addr_next  = addr_reg - 32'(len_eff - mbps_pkg::LEN_W'(1));
            end
        end

        if (restart)
        begin
            addr_next     = cfg_data[31:0];
            seen_next     = '0;
            finished_next = 1'b0;
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_addr_next  = out_addr_reg;
        out_done_next  = out_done_reg;
        if (advance)
        begin
            out_valid_next = pend_valid_reg
                             && (pend_kind_reg == mbps_pkg::PEND_DONE || hit);
            out_done_next  = pend_kind_reg == mbps_pkg::PEND_DONE;
            out_addr_next  = (pend_kind_reg == mbps_pkg::PEND_DONE) ? 32'd0 : pend_addr_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg       <= 32'd0;
            seen_reg       <= '0;
            finished_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            addr_reg       <= addr_next;
            seen_reg       <= seen_next;
            finished_reg   <= finished_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pend_kind_reg <= pend_kind_next;
        pend_addr_reg <= pend_addr_next;
        out_addr_reg  <= out_addr_next;
        out_done_reg  <= out_done_next;
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_addr_reg;
    assign m_axis_tuser[0] = out_done_reg;

endmodule

// File: rtl/core/mbps_checker.sv
`timescale 1ns / 1ps
// mbps_checker: port-level assertions for masked_byte_pattern_scanner_unit
// depends on mbps_pkg; bound to the top level at the end of this file

module mbps_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,
    input  logic [0:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,
    input  logic [0:0]  m_axis_tuser
);

    logic [2:0] restart_hist_reg;
    logic       restart;
    logic       done_xact;

    assign restart   = cfg_we && (cfg_index == mbps_pkg::REG_START_ADDR);
    assign done_xact = m_axis_tvalid && m_axis_tready && m_axis_tuser[0];

    // recent scan restarts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            restart_hist_reg <= 3'd0;
        else
            restart_hist_reg <= {restart_hist_reg[1:0], restart};
    end

    // a stalled result stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result withdrawn while stalled");

    // a done result carries address zero
    a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == 32'd0)
        else $error("done result with non-zero address");

    // nothing follows a done transaction unless the scan was restarted
    a_quiet_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        done_xact && !restart && restart_hist_reg == 3'd0 |=> !m_axis_tvalid)
        else $error("result after scan done");

    // an empty output register never blocks the byte stream
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    // accepted byte transactions and register writes carry no unknowns
    a_input_known: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) || cfg_we |->
            !$isunknown({s_axis_tdata, s_axis_tuser, cfg_index, cfg_data}))
        else $error("unknown bits on an accepted input");

endmodule

bind masked_byte_pattern_scanner_unit mbps_checker u_mbps_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
